// ===== hw/rtl/tfn_pkg.sv =====
// tfn_pkg: widths, stage word types and latency of the triangle face normal block.
// No dependencies; used by every module of the block and by its checker.
`default_nettype none

package tfn_pkg;

	localparam int COORD_W = 24;               // vertex coordinate, signed Q12.12
	localparam int EDGE_W  = COORD_W + 1;      // edge vector, exact
	localparam int PROD_W  = 2 * EDGE_W;       // one cross term
	localparam int NRM_W   = PROD_W + 1;       // cross product component
	localparam int MAG_W   = NRM_W - 1;        // |component|
	localparam int HALF_W  = (MAG_W + 1) / 2;  // low half for split squaring
	localparam int HI_W    = MAG_W - HALF_W;   // high half
	localparam int SQ_W    = 2 * MAG_W;        // component squared
	localparam int SUM_W   = SQ_W + 2;         // squared length
	localparam int WIDE_W  = SUM_W + 34;       // root search accumulators
	localparam int QW      = 15;               // magnitude bits of a Q1.14 result
	localparam int OUT_W   = 16;               // result component
	localparam int NLANE   = 3;
	localparam int VSH     = QW + 1;           // start scale of the cross term
	localparam int PSH     = 2 * QW;           // start scale of the square term
	localparam int RSH     = 2 * QW;           // 2^30 bound scale
	localparam int FRONT_STAGES = 6;
	localparam int LATENCY = FRONT_STAGES + QW + 2;

	// front end result: squared components, signs, squared length
	typedef struct packed {
		logic                        vld;
		logic [SUM_W-1:0]            s;
		logic [NLANE-1:0][SQ_W-1:0]  sq;
		logic [NLANE-1:0]            neg;
	} tfn_front_t;

	// one component's root search state
	typedef struct packed {
		logic signed [WIDE_W-1:0] t;   // (2q-1)^2 * S
		logic signed [WIDE_W-1:0] v;   // (2q-1) * S, scaled to the current bit
		logic signed [WIDE_W-1:0] r;   // 2^30 * n^2
		logic [QW-1:0]            q;
		logic                     neg;
	} tfn_lane_t;

	// word handed from cell to cell
	typedef struct packed {
		logic                     vld;
		logic                     deg;
		logic signed [WIDE_W-1:0] p;   // S, scaled to the current bit
		tfn_lane_t [NLANE-1:0]    lane;
	} tfn_chain_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tfn_front.sv =====
// tfn_front: edge vectors, cross product, squared components and squared length.
// Six pipeline stages; depends on tfn_pkg.
`default_nettype none

module tfn_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_vld,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  a_x,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  a_y,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  a_z,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  b_x,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  b_y,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  b_z,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  c_x,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  c_y,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  c_z,
	output tfn_pkg::tfn_front_t                      fo
);
	import tfn_pkg::*;

	logic [FRONT_STAGES-1:0] vld_q;

	logic signed [EDGE_W-1:0] e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [PROD_W-1:0] prod_s2 [2*NLANE];
	logic signed [NRM_W-1:0]  n_s3 [NLANE];
	logic [2*HI_W-1:0]        hh_s4 [NLANE];
	logic [HI_W+HALF_W-1:0]   hl_s4 [NLANE];
	logic [2*HALF_W-1:0]      ll_s4 [NLANE];
	logic [NLANE-1:0]         neg_s4, neg_s5, neg_s6;
	logic [SQ_W-1:0]          sq_s5 [NLANE];
	logic [SQ_W-1:0]          sq_s6 [NLANE];
	logic [SUM_W-1:0]         s_s6;

	logic [MAG_W-1:0]         mag [NLANE];
	logic signed [NRM_W-1:0]  nneg [NLANE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[FRONT_STAGES-2:0], in_vld};
		end
	end

	always_comb begin
		for (int k = 0; k < NLANE; k++) begin
			nneg[k] = -n_s3[k];
			mag[k]  = n_s3[k][NRM_W-1] ? nneg[k][MAG_W-1:0] : n_s3[k][MAG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		// s1: edges from the first vertex
		e1x_s1 <= EDGE_W'(b_x) - EDGE_W'(a_x);
		e1y_s1 <= EDGE_W'(b_y) - EDGE_W'(a_y);
		e1z_s1 <= EDGE_W'(b_z) - EDGE_W'(a_z);
		e2x_s1 <= EDGE_W'(c_x) - EDGE_W'(a_x);
		e2y_s1 <= EDGE_W'(c_y) - EDGE_W'(a_y);
		e2z_s1 <= EDGE_W'(c_z) - EDGE_W'(a_z);
		// s2: cross terms
		prod_s2[0] <= e1y_s1 * e2z_s1;
		prod_s2[1] <= e1z_s1 * e2y_s1;
		prod_s2[2] <= e1z_s1 * e2x_s1;
		prod_s2[3] <= e1x_s1 * e2z_s1;
		prod_s2[4] <= e1x_s1 * e2y_s1;
		prod_s2[5] <= e1y_s1 * e2x_s1;
		for (int k = 0; k < NLANE; k++) begin
			// s3: components
			n_s3[k] <= NRM_W'(prod_s2[2*k]) - NRM_W'(prod_s2[2*k+1]);
			// s4: split squaring of the magnitude
			neg_s4[k] <= n_s3[k][NRM_W-1];
			hh_s4[k]  <= mag[k][MAG_W-1:HALF_W] * mag[k][MAG_W-1:HALF_W];
			hl_s4[k]  <= mag[k][MAG_W-1:HALF_W] * mag[k][HALF_W-1:0];
			ll_s4[k]  <= mag[k][HALF_W-1:0] * mag[k][HALF_W-1:0];
			// s5: recombine partial products
			neg_s5[k] <= neg_s4[k];
			sq_s5[k]  <= (SQ_W'(hh_s4[k]) << (2 * HALF_W))
				+ (SQ_W'(hl_s4[k]) << (HALF_W + 1)) + SQ_W'(ll_s4[k]);
			// s6
			neg_s6[k] <= neg_s5[k];
			sq_s6[k]  <= sq_s5[k];
		end
		s_s6 <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2]);
	end

	always_comb begin
		fo.vld = vld_q[FRONT_STAGES-1];
		fo.s   = s_s6;
		fo.neg = neg_s6;
		for (int k = 0; k < NLANE; k++) begin
			fo.sq[k] = sq_s6[k];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tfn_cell.sv =====
// tfn_cell: one bit of the rounded magnitude search for all three components.
// Shift and add only; depends on tfn_pkg.
`default_nettype none

module tfn_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tfn_pkg::tfn_chain_t  ci,
	output tfn_pkg::tfn_chain_t       co
);
	import tfn_pkg::*;

	tfn_chain_t               nxt;
	logic signed [WIDE_W-1:0] tc [NLANE];
	logic                     ok [NLANE];
	logic signed [WIDE_W-1:0] vn [NLANE];

	// try this bit: (2q'-1)^2 S = T + V + P; keep it if within the bound
	always_comb begin
		nxt     = ci;
		nxt.p   = ci.p >>> 2;
		for (int k = 0; k < NLANE; k++) begin
			tc[k] = ci.lane[k].t + ci.lane[k].v + ci.p;
			ok[k] = (tc[k] <= ci.lane[k].r);
			vn[k] = ok[k] ? (ci.lane[k].v + (ci.p <<< 1)) : ci.lane[k].v;
			nxt.lane[k].t = ok[k] ? tc[k] : ci.lane[k].t;
			nxt.lane[k].v = vn[k] >>> 1;
			nxt.lane[k].q = {ci.lane[k].q[QW-2:0], ok[k]};
		end
	end

	// only the valid bit is reset; the data fields just follow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			co.vld <= 1'b0;
		end else begin
			co <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_face_normal.sv =====
// triangle_face_normal: unit face normal of a triangle, Q12.12 in, Q1.14 out.
// Instantiates tfn_front and a row of tfn_cell; depends on tfn_pkg.
//
// Command channel: a triangle word (three vertices a, b, c) is taken at every
// rising edge where start is high and busy is low. busy stays low: the block
// takes one triangle every cycle, back to back.
// Result channel: done is high for exactly one cycle with normal_x/y/z and
// degenerate; the receiver has no way to stall, and none is needed, since
// each triangle gives exactly one result.
// Pipeline: 23 register stages in all lie between the command and done:
// 6 front stages (edges, cross terms, components, split squares, squares,
// squared length), one load stage, 15 search cells (one result bit each,
// most significant first) and one output register. Throughput: one per cycle.
// Each cell finds one bit of q, the largest value with (2q-1)^2*S <= 2^30*n^2,
// keeping (2q-1)^2*S and (2q-1)*S by shifts and adds, so no divider or root.
// A zero squared length gives a zero normal with degenerate set.
// Reset clears only the valid bits of the pipeline; no result comes out of
// words in flight at reset.
`default_nettype none

module triangle_face_normal (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  a_x,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  a_y,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  a_z,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  b_x,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  b_y,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  b_z,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  c_x,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  c_y,
	input  wire logic signed [tfn_pkg::COORD_W-1:0]  c_z,
	output logic                                     done,
	output logic signed [tfn_pkg::OUT_W-1:0]         normal_x,
	output logic signed [tfn_pkg::OUT_W-1:0]         normal_y,
	output logic signed [tfn_pkg::OUT_W-1:0]         normal_z,
	output logic                                     degenerate
);
	import tfn_pkg::*;

	tfn_front_t               fo;
	tfn_chain_t               load_d;
	tfn_chain_t               load_q;
	tfn_chain_t               chain [QW+1];
	logic signed [WIDE_W-1:0] s_w;
	logic signed [OUT_W-1:0]  res [NLANE];
	logic signed [OUT_W-1:0]  mag [NLANE];

	assign busy = 1'b0;

	tfn_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start),
		.a_x    (a_x),
		.a_y    (a_y),
		.a_z    (a_z),
		.b_x    (b_x),
		.b_y    (b_y),
		.b_z    (b_z),
		.c_x    (c_x),
		.c_y    (c_y),
		.c_z    (c_z),
		.fo     (fo)
	);

	// load: start with q = 0, i.e. (2q-1) = -1, scaled for the top bit
	always_comb begin
		s_w        = WIDE_W'(fo.s);
		load_d.vld = fo.vld;
		load_d.deg = (fo.s == '0);
		load_d.p   = s_w <<< PSH;
		for (int k = 0; k < NLANE; k++) begin
			load_d.lane[k].t   = s_w;
			load_d.lane[k].v   = -(s_w <<< VSH);
			load_d.lane[k].r   = WIDE_W'(fo.sq[k]) <<< RSH;
			load_d.lane[k].q   = '0;
			load_d.lane[k].neg = fo.neg[k];
		end
	end

	// only the valid bit is reset; the data fields just follow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q.vld <= 1'b0;
		end else begin
			load_q <= load_d;
		end
	end

	assign chain[0] = load_q;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		tfn_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ci     (chain[i]),
			.co     (chain[i+1])
		);
	end

	// sign and degenerate override
	always_comb begin
		for (int k = 0; k < NLANE; k++) begin
			mag[k] = OUT_W'(chain[QW].lane[k].q);
			if (chain[QW].deg) begin
				res[k] = '0;
			end else if (chain[QW].lane[k].neg) begin
				res[k] = -mag[k];
			end else begin
				res[k] = mag[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= chain[QW].vld;
		end
	end

	always_ff @(posedge clk) begin
		normal_x   <= res[0];
		normal_y   <= res[1];
		normal_z   <= res[2];
		degenerate <= chain[QW].deg;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tfn_checker.sv =====
// tfn_checker: port-level checks of triangle_face_normal, bound to the top level.
// Depends on tfn_pkg.
`default_nettype none

module tfn_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic                                busy,
	input  wire logic                                done,
	input  wire logic signed [tfn_pkg::OUT_W-1:0]    normal_x,
	input  wire logic signed [tfn_pkg::OUT_W-1:0]    normal_y,
	input  wire logic signed [tfn_pkg::OUT_W-1:0]    normal_z,
	input  wire logic                                degenerate
);
	import tfn_pkg::*;

	localparam logic signed [OUT_W-1:0] ONE_Q = OUT_W'(1 << (QW - 1));

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching command");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate result not zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> normal_x <= ONE_Q && normal_x >= -ONE_Q
			&& normal_y <= ONE_Q && normal_y >= -ONE_Q
			&& normal_z <= ONE_Q && normal_z >= -ONE_Q)
		else $error("normal component out of range");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.normal_x   (normal_x),
	.normal_y   (normal_y),
	.normal_z   (normal_z),
	.degenerate (degenerate)
);

`default_nettype wire
